### hdl/usv_pkg.sv
//==============================================================================
// usv_pkg
// Shared types, codes and constants of the UTF-8 sequence validator.
//==============================================================================
`default_nettype none

package usv_pkg;

    // Widths of the stream fields
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned CP_W        = 31;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_TRUNC   = 2'd2
    } status_t;

    // What a byte means when it stands in lead position
    typedef enum logic [1:0] {
        KIND_ASCII,
        KIND_STRAY,
        KIND_LEAD
    } lead_kind_t;

    // One classified byte as it travels from front to back
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        lead_kind_t        kind;
        logic [LEN_W-1:0]  lead_len;
        logic [4:0]        lead_bits;
        logic              cont_ok;
        logic              last;
    } q_entry_t;

    // One result item
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] seq_length;
        logic [CP_W-1:0]  code_point;
    } result_t;

    // Largest value the next shorter form carries, by declared length
    function automatic logic [CP_W-1:0] overlong_limit(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] lim;
        begin
            unique case (len)
                3'd2:    lim = 31'h0000007F;
                3'd3:    lim = 31'h000007FF;
                3'd4:    lim = 31'h0000FFFF;
                3'd5:    lim = 31'h001FFFFF;
                3'd6:    lim = 31'h03FFFFFF;
                default: lim = '0;
            endcase
            return lim;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/usv_front.sv
//==============================================================================
// usv_front
// Accepts input beats and classifies each byte as lead and as continuation.
//==============================================================================
`default_nettype none

module usv_front
(
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [usv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  wire logic                              s_axis_tlast,   // end_of_buffer
    input  wire logic                              q_full,
    output logic                                   q_push,
    output usv_pkg::q_entry_t                      q_entry
);
    import usv_pkg::*;

    logic [DATA_W-1:0] b;

    assign b = s_axis_tdata[DATA_W-1:0];

    // Take a beat whenever the queue has room
    assign s_axis_tready = ~q_full;
    assign q_push        = s_axis_tvalid & ~q_full;

    // Decode the lead form and the continuation form
    always_comb
    begin
        q_entry.data_byte = b;
        q_entry.last      = s_axis_tlast;
        q_entry.cont_ok   = (b[7:6] == 2'b10);
        q_entry.kind      = KIND_LEAD;
        q_entry.lead_len  = 3'd1;
        q_entry.lead_bits = '0;
        if (b[7] == 1'b0)
        begin
            q_entry.kind = KIND_ASCII;
        end
        else if (b[7:5] == 3'b110)
        begin
            q_entry.lead_len  = 3'd2;
            q_entry.lead_bits = b[4:0];
        end
        else if (b[7:4] == 4'b1110)
        begin
            q_entry.lead_len  = 3'd3;
            q_entry.lead_bits = {1'b0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            q_entry.lead_len  = 3'd4;
            q_entry.lead_bits = {2'b00, b[2:0]};
        end
        else if (b[7:2] == 6'b111110)
        begin
            q_entry.lead_len  = 3'd5;
            q_entry.lead_bits = {3'b000, b[1:0]};
        end
        else if (b[7:1] == 7'b1111110)
        begin
            q_entry.lead_len  = 3'd6;
            q_entry.lead_bits = {4'b0000, b[0]};
        end
        else
        begin
            q_entry.kind = KIND_STRAY;
        end
    end

endmodule

`default_nettype wire

### hdl/usv_queue.sv
//==============================================================================
// usv_queue
// Short first-in first-out queue of classified bytes between front and back.
//==============================================================================
`default_nettype none

module usv_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire usv_pkg::q_entry_t push_entry,
    output logic                   full,
    output logic                   q_valid,
    input  wire logic              pop,
    output usv_pkg::q_entry_t      pop_entry
);
    import usv_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign q_valid   = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry store
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");
`endif

endmodule

`default_nettype wire

### hdl/usv_back.sv
//==============================================================================
// usv_back
// Gathers sequences from classified bytes and holds results in an output stage.
//==============================================================================
`default_nettype none

module usv_back
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire usv_pkg::q_entry_t               q_entry,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [usv_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import usv_pkg::*;

    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0] decl_len_reg, decl_len_next;
    logic [CP_W-1:0]  accum_reg, accum_next;
    logic             bad_reg, bad_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             emit;
    result_t          res;
    logic [CP_W-1:0]  acc_shift;
    logic [LEN_W-1:0] left_dec;
    logic             bad_upd;
    logic             out_free;

    assign acc_shift = {accum_reg[CP_W-7:0], q_entry.data_byte[5:0]};
    assign left_dec  = bytes_left_reg - 1'b1;
    assign bad_upd   = bad_reg | ~q_entry.cont_ok;
    assign out_free  = ~out_valid_reg | m_axis_tready;
    assign q_pop     = q_valid & (out_free | ~emit);

    // Decode the head byte against the sequence state
    always_comb
    begin
        emit            = 1'b0;
        res.code_point  = '0;
        res.seq_length  = 3'd1;
        res.status      = STATUS_OK;
        bytes_left_next = bytes_left_reg;
        decl_len_next   = decl_len_reg;
        accum_next      = accum_reg;
        bad_next        = bad_reg;
        if (bytes_left_reg == '0)
        begin
            unique case (q_entry.kind)
                KIND_ASCII:
                begin
                    emit           = 1'b1;
                    res.code_point = {{(CP_W-DATA_W){1'b0}}, q_entry.data_byte};
                end
                KIND_LEAD:
                begin
                    if (q_entry.last)
                    begin
                        emit           = 1'b1;
                        res.seq_length = q_entry.lead_len;
                        res.status     = STATUS_TRUNC;
                    end
                    else
                    begin
                        decl_len_next   = q_entry.lead_len;
                        bytes_left_next = q_entry.lead_len - 1'b1;
                        accum_next      = {{(CP_W-5){1'b0}}, q_entry.lead_bits};
                        bad_next        = 1'b0;
                    end
                end
                default:
                begin
                    emit       = 1'b1;
                    res.status = STATUS_INVALID;
                end
            endcase
        end
        else if (left_dec != '0)
        begin
            // Mid sequence: gather, or cut short at buffer end
            if (q_entry.last)
            begin
                emit            = 1'b1;
                res.seq_length  = decl_len_reg;
                res.status      = STATUS_TRUNC;
                bytes_left_next = '0;
                decl_len_next   = '0;
                accum_next      = '0;
                bad_next        = 1'b0;
            end
            else
            begin
                bytes_left_next = left_dec;
                accum_next      = acc_shift;
                bad_next        = bad_upd;
            end
        end
        else
        begin
            // Final byte: check form and overlong value
            emit           = 1'b1;
            res.seq_length = decl_len_reg;
            if (bad_upd || (acc_shift <= overlong_limit(decl_len_reg)))
            begin
                res.status = STATUS_INVALID;
            end
            else
            begin
                res.code_point = acc_shift;
            end
            bytes_left_next = '0;
            decl_len_next   = '0;
            accum_next      = '0;
            bad_next        = 1'b0;
        end
    end

    // Load or drain the output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            decl_len_reg   <= '0;
            accum_reg      <= '0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                bytes_left_reg <= bytes_left_next;
                decl_len_reg   <= decl_len_next;
                accum_reg      <= accum_next;
                bad_reg        <= bad_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds without reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W-LEN_W-STATUS_W){1'b0}},
                            out_reg.status, out_reg.seq_length, out_reg.code_point};

`ifndef ASSERT_OFF
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd5)
        else $error("too many continuation bytes pending");

    a_left_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != '0) |-> (decl_len_reg >= 3'd2) && (decl_len_reg <= 3'd6)
                                   && (bytes_left_reg < decl_len_reg))
        else $error("pending count disagrees with declared length");

    a_bad_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != STATUS_OK) |-> out_reg.code_point == '0)
        else $error("failed result carries a code point");
`endif

endmodule

`default_nettype wire

### hdl/utf8_sequence_validator_core.sv
//==============================================================================
// utf8_sequence_validator_core
// UTF-8 validator for 1 to 6 byte sequences with overlong and truncation check.
//==============================================================================
// channel      | dir | beat content
// s_axis       | in  | tdata[7:0] data_byte, tlast end_of_buffer
// m_axis       | out | tdata[30:0] code_point, [33:31] seq_length, [35:34] status
//
// One byte per cycle while the queue has room: the front classifies a byte
// as it is taken, the back consumes one queued byte per cycle unless stalled
// and loads the output stage; each result passes queue and output stage.
// The queue lets the input keep flowing for QUEUE_DEPTH beats while the
// output is stalled; the back only stops for bytes that produce a result.
// Asynchronous active-low reset empties the queue and output stage.
//==============================================================================
`default_nettype none

module utf8_sequence_validator_core
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [usv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  wire logic                             s_axis_tlast,  // end_of_buffer
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [30:0] code_point, [33:31] seq_length, [35:34] status, [39:36] zero
    output logic [usv_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import usv_pkg::*;

    q_entry_t push_entry;
    q_entry_t pop_entry;
    logic     push;
    logic     pop;
    logic     full;
    logic     q_valid;

    // Accept and classify
    usv_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    // Decouple front and back
    usv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .q_valid    (q_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    // Gather sequences and emit results
    usv_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (pop_entry),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### tb/sv/utf8_stream_checker.sv
//==============================================================================
// utf8_stream_checker
// Watches both stream channels of the UTF-8 validator. It decodes every
// accepted input byte with its own sequence tracker, queues the result that
// byte should cause, and compares each output beat field by field with the
// oldest queued result.
//==============================================================================

module utf8_stream_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [usv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [usv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                                   mismatch_count,
    output int                                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import usv_pkg::*;

    // Decoded results still waiting for their output beat
    result_t pending_results[$];

    // Sequence tracker
    logic [LEN_W-1:0] cont_left;
    logic [LEN_W-1:0] decl_len;
    logic [CP_W-1:0]  value_acc;
    logic             cont_bad;

    result_t seen;
    result_t want;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // Payload bits carried by a sequence of the given length
    function automatic int payload_bits(input logic [LEN_W-1:0] len);
        case (len)
            3'd1:    return 7;
            3'd2:    return 11;
            3'd3:    return 16;
            3'd4:    return 21;
            3'd5:    return 26;
            default: return 31;
        endcase
    endfunction

    function automatic void queue_result(input status_t st, input logic [LEN_W-1:0] len,
                                         input logic [CP_W-1:0] cp);
        result_t r;
        r.status     = st;
        r.seq_length = len;
        r.code_point = cp;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_tracker();
        cont_left = '0;
        decl_len  = '0;
        value_acc = '0;
        cont_bad  = 1'b0;
    endfunction

    // Advance the tracker by one byte and queue whatever result it causes
    function automatic void decode_byte(input logic [7:0] b, input logic at_end);
        logic [LEN_W-1:0] len;
        logic [4:0]       lead;
        logic [CP_W-1:0]  cp;
        if (cont_left == '0) begin
            len  = '0;
            lead = '0;
            casez (b)
                8'b0???????: queue_result(STATUS_OK, 3'd1, {23'd0, b});
                8'b110?????: begin len = 3'd2; lead = b[4:0];         end
                8'b1110????: begin len = 3'd3; lead = {1'b0, b[3:0]}; end
                8'b11110???: begin len = 3'd4; lead = {2'b0, b[2:0]}; end
                8'b111110??: begin len = 3'd5; lead = {3'b0, b[1:0]}; end
                8'b1111110?: begin len = 3'd6; lead = {4'b0, b[0]};   end
                // stray continuation, 0xFE or 0xFF in lead position
                default:     queue_result(STATUS_INVALID, 3'd1, '0);
            endcase
            if (len != '0) begin
                if (at_end) begin
                    queue_result(STATUS_TRUNC, len, '0);
                    clear_tracker();
                end
                else begin
                    decl_len  = len;
                    cont_left = len - 3'd1;
                    value_acc = {26'd0, lead};
                    cont_bad  = 1'b0;
                end
            end
        end
        else begin
            // a malformed byte still counts toward the declared length
            if (b[7:6] != 2'b10)
                cont_bad = 1'b1;
            value_acc = {value_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left != '0) begin
                if (at_end) begin
                    queue_result(STATUS_TRUNC, decl_len, '0);
                    clear_tracker();
                end
            end
            else begin
                // overlong when the value fits in the next shorter form
                cp = value_acc >> payload_bits(decl_len - 3'd1);
                if (cont_bad || cp == '0)
                    queue_result(STATUS_INVALID, decl_len, '0);
                else
                    queue_result(STATUS_OK, decl_len, value_acc);
                clear_tracker();
            end
        end
    endfunction

    // Track input beats, then check output beats against the oldest result
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_tracker();
            pending_results.delete();
            outstanding <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata[7:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                seen = result_t'(m_axis_tdata[CP_W+LEN_W+STATUS_W-1:0]);
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat: tdata=%h", m_axis_tdata);
                    mismatch_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, seen.status);
                        mismatch_count++;
                    end
                    if (seen.seq_length !== want.seq_length) begin
                        $error("seq_length: expected %0d, actual %0d",
                               want.seq_length, seen.seq_length);
                        mismatch_count++;
                    end
                    if (seen.code_point !== want.code_point) begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, seen.code_point);
                        mismatch_count++;
                    end
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

### tb/sv/testbench.sv
//==============================================================================
// testbench
// Drives a UTF-8 byte stream into the sequence validator: a directed set of
// lengths, overlongs, stray bytes, malformed and truncated sequences, then
// mostly well-formed random sequences mixed with noise. Both channels stall
// at random, and the output is held off once long enough to back up the input.
//==============================================================================

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import usv_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int outstanding;
    int bytes_sent  = 0;
    int cycle_count = 0;
    int rx_cycle    = 0;

    utf8_sequence_validator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    utf8_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Give up when the run takes far longer than any correct one
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Output side: random stalls, one long hold-off, one stretch always ready
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 400 && rx_cycle < 700)
            m_axis_tready <= 1'b0;
        else if (rx_cycle >= 1500 && rx_cycle < 2000)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 28);
    end

    // Offer one byte and hold it until the beat is taken
    task automatic send_byte(input logic [7:0] b, input logic at_end);
        if (bytes_sent < 800 || bytes_sent >= 1100) begin
            while ($urandom_range(0, 99) < 28) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= at_end;
        @(negedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    // One sequence of random length and content, sometimes broken or cut short
    task automatic send_sequence();
        int         len;
        int         cut_at;
        logic       near_overlong;
        logic [7:0] b;
        len           = $urandom_range(1, 6);
        near_overlong = ($urandom_range(0, 3) == 0);
        cut_at        = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(0, len - 2) : -1;
        case (len)
            1:       b = {1'b0, 7'($urandom_range(0, 127))};
            2:       b = {3'b110, near_overlong ? 5'($urandom_range(0, 1))
                                                : 5'($urandom_range(0, 31))};
            3:       b = {4'b1110, near_overlong ? 4'h0 : 4'($urandom_range(0, 15))};
            4:       b = {5'b11110, near_overlong ? 3'h0 : 3'($urandom_range(0, 7))};
            5:       b = {6'b111110, near_overlong ? 2'h0 : 2'($urandom_range(0, 3))};
            default: b = {7'b1111110, near_overlong ? 1'b0 : 1'($urandom_range(0, 1))};
        endcase
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 24) == 0)
                    b = 8'($urandom_range(0, 255));
                else if (i == 1 && near_overlong)
                    b = {2'b10, 6'($urandom_range(0, 63) >> $urandom_range(0, 5))};
                else
                    b = {2'b10, 6'($urandom_range(0, 63))};
            end
            if (i == cut_at) begin
                send_byte(b, 1'b1);
                return;
            end
            send_byte(b, (i == len - 1) && ($urandom_range(0, 7) == 0));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single bytes at the edges and stray leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Shortest two-byte value, then an overlong one
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Largest three-byte value, ending the buffer on a complete sequence
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Overlong four-byte form
        send_byte(8'hF0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // Five-byte value above the Unicode range
        send_byte(8'hF8, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // Largest six-byte value
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        // Malformed continuation that looks like ASCII
        send_byte(8'hC2, 1'b0);
        send_byte(8'h41, 1'b0);
        // Buffer ends mid-sequence, on the lead itself, and after a bad byte
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hC3, 1'b1);

        // Random part: mostly sequences, some raw noise bytes
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 12)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else
                send_sequence();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every queued result before the verdict
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
